/* src/jloc_pkg.sv */
package jloc_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned ETA_W       = 13;
  localparam int unsigned PHI_W       = 12;
  localparam int unsigned PT_W        = 16;
  localparam int unsigned DR_W        = 27;
  localparam int unsigned ETA_MAX_W   = 12;
  localparam int unsigned JET_INDEX_W = 6;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 27;

  // Widths inside the distance pipeline.
  localparam int unsigned DETA_MAG_W = ETA_W;      // |deta| <= 8191
  localparam int unsigned DPHI_MAG_W = PHI_W;      // |dphi| <= 2048
  localparam int unsigned SQ_ETA_W   = 2 * DETA_MAG_W;
  localparam int unsigned SQ_PHI_W   = 2 * DPHI_MAG_W - 1;

  // Input command codes.
  localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LEPTON = 2'd1;
  localparam logic [CMD_W-1:0] CMD_JET    = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_DR_LIMIT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PT_MIN   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ETA_MAX  = 2'd2;

  // Configuration values after reset.
  localparam logic [DR_W-1:0]      DR_LIMIT_RESET = 27'd68121;
  localparam logic [PT_W-1:0]      PT_MIN_RESET   = 16'd100;
  localparam logic [ETA_MAX_W-1:0] ETA_MAX_RESET  = 12'd1565;

  typedef struct packed {
    logic clear_event;
    logic store_lepton;
    logic load_jet;
    logic issue;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cut_pass;
    logic no_leptons;
    logic last_issue;
    logic pipe_busy;
    logic hit;
  } dp_status_t;

endpackage

/* src/jloc_ctrl.sv */
module jloc_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  input  logic [jloc_pkg::CMD_W-1:0]       cmd_i,
  input  jloc_pkg::dp_status_t             status_i,
  output jloc_pkg::ctrl_cmd_t              cmd_o,
  output logic                             busy
);
  import jloc_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_i)
            CMD_START:  cmd_o.clear_event  = 1'b1;
            CMD_LEPTON: cmd_o.store_lepton = 1'b1;
            CMD_JET: begin
              cmd_o.load_jet = 1'b1;
              if (status_i.cut_pass) begin
                state_d = status_i.no_leptons ? ST_DRAIN : ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        cmd_o.issue = 1'b1;
        if (status_i.last_issue) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          cmd_o.emit = !status_i.hit;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_scan_not_abandoned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |=> (state_q != ST_IDLE))
    else $error("scan left without draining the pipeline");

  a_no_accept_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !(cmd_o.clear_event || cmd_o.store_lepton || cmd_o.load_jet))
    else $error("item taken while busy");

  a_emit_ends_jet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> (state_q == ST_IDLE))
    else $error("result given while the jet is still in work");

endmodule

/* src/jloc_datapath.sv */
module jloc_datapath #(
  parameter int unsigned MAX_LEPTONS = 16,
  parameter int unsigned MAX_JETS    = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic signed [jloc_pkg::ETA_W-1:0]    eta_i,
  input  logic signed [jloc_pkg::PHI_W-1:0]    phi_i,
  input  logic [jloc_pkg::PT_W-1:0]            pt_i,
  input  logic                                 cfg_valid_i,
  input  logic [jloc_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [jloc_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  jloc_pkg::ctrl_cmd_t                  cmd_i,
  output jloc_pkg::dp_status_t                 status_o,
  output logic                                 result_valid_o,
  output logic [jloc_pkg::JET_INDEX_W-1:0]     jet_index_o
);
  import jloc_pkg::*;

  localparam int unsigned IW = (MAX_LEPTONS > 1) ? $clog2(MAX_LEPTONS) : 1;
  localparam int unsigned CW = $clog2(MAX_LEPTONS + 1);
  localparam int unsigned JW = $clog2(MAX_JETS);

  // Configuration registers.
  logic [DR_W-1:0]      dr_limit_q;
  logic [PT_W-1:0]      pt_min_q;
  logic [ETA_MAX_W-1:0] eta_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dr_limit_q <= DR_LIMIT_RESET;
      pt_min_q   <= PT_MIN_RESET;
      eta_max_q  <= ETA_MAX_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DR_LIMIT: dr_limit_q <= cfg_data_i[DR_W-1:0];
        CFG_PT_MIN:   pt_min_q   <= cfg_data_i[PT_W-1:0];
        CFG_ETA_MAX:  eta_max_q  <= cfg_data_i[ETA_MAX_W-1:0];
        default: ;
      endcase
    end
  end

  // Kinematic cut on the incoming jet.
  logic [ETA_W-1:0] eta_in_mag;
  logic             cut_pass;

  assign eta_in_mag = eta_i[ETA_W-1] ? ETA_W'(-eta_i) : ETA_W'(eta_i);
  assign cut_pass   = (pt_i >= pt_min_q) && (eta_in_mag <= {1'b0, eta_max_q});

  // Event counters and scan control.
  logic [CW-1:0] lep_count_q;
  logic [JW-1:0] jet_cnt_q;
  logic [IW-1:0] rd_idx_q;
  logic          lep_full;
  logic          v1_q, v2_q, v3_q, hit_q;
  logic          result_valid_q;

  assign lep_full = !(lep_count_q < CW'(MAX_LEPTONS));

  // Distance pipeline payload.
  logic [JW-1:0]                jet_idx_q;
  logic signed [ETA_W-1:0]      jet_eta_q;
  logic signed [PHI_W-1:0]      jet_phi_q;
  logic [ETA_W-1:0]             eta_mem [MAX_LEPTONS];
  logic [PHI_W-1:0]             phi_mem [MAX_LEPTONS];
  logic signed [ETA_W-1:0]      rd_eta_q;
  logic signed [PHI_W-1:0]      rd_phi_q;
  logic signed [ETA_W:0]        deta;
  logic signed [PHI_W-1:0]      dphi;
  logic [DETA_MAG_W-1:0]        deta_mag_d, deta_mag_q;
  logic [DPHI_MAG_W-1:0]        dphi_mag_d, dphi_mag_q;
  logic [SQ_ETA_W-1:0]          sq_eta_q;
  logic [SQ_PHI_W-1:0]          sq_phi_q;
  logic [DR_W-1:0]              dist_sq;
  logic [JET_INDEX_W-1:0]       jet_index_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lep_count_q    <= '0;
      jet_cnt_q      <= '0;
      rd_idx_q       <= '0;
      v1_q           <= 1'b0;
      v2_q           <= 1'b0;
      v3_q           <= 1'b0;
      hit_q          <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear_event) begin
        lep_count_q <= '0;
        jet_cnt_q   <= '0;
      end
      if (cmd_i.store_lepton && !lep_full) begin
        lep_count_q <= lep_count_q + CW'(1);
      end
      if (cmd_i.load_jet) begin
        if (jet_cnt_q != JW'(MAX_JETS - 1)) begin
          jet_cnt_q <= jet_cnt_q + JW'(1);
        end
        rd_idx_q <= '0;
      end else if (cmd_i.issue) begin
        rd_idx_q <= rd_idx_q + IW'(1);
      end
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (cmd_i.load_jet) begin
        hit_q <= 1'b0;
      end else if (v3_q && (dist_sq < dr_limit_q)) begin
        hit_q <= 1'b1;
      end
      result_valid_q <= cmd_i.emit;
    end
  end

  // Lepton store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_lepton && !lep_full) begin
      eta_mem[lep_count_q[IW-1:0]] <= eta_i;
      phi_mem[lep_count_q[IW-1:0]] <= phi_i;
    end
    if (cmd_i.issue) begin
      rd_eta_q <= eta_mem[rd_idx_q];
      rd_phi_q <= phi_mem[rd_idx_q];
    end
  end

  // The eta difference keeps its full range; the phi difference wraps.
  assign deta       = {jet_eta_q[ETA_W-1], jet_eta_q} - {rd_eta_q[ETA_W-1], rd_eta_q};
  assign dphi       = jet_phi_q - rd_phi_q;
  assign deta_mag_d = deta[ETA_W] ? DETA_MAG_W'(-deta) : DETA_MAG_W'(deta);
  assign dphi_mag_d = dphi[PHI_W-1] ? DPHI_MAG_W'(-dphi) : DPHI_MAG_W'(dphi);
  assign dist_sq    = DR_W'(sq_eta_q) + DR_W'(sq_phi_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_jet) begin
      jet_idx_q <= jet_cnt_q;
      jet_eta_q <= eta_i;
      jet_phi_q <= phi_i;
    end
    deta_mag_q <= deta_mag_d;
    dphi_mag_q <= dphi_mag_d;
    sq_eta_q   <= deta_mag_q * deta_mag_q;
    sq_phi_q   <= SQ_PHI_W'(dphi_mag_q) * SQ_PHI_W'(dphi_mag_q);
    if (cmd_i.emit) begin
      jet_index_q <= JET_INDEX_W'(jet_idx_q);
    end
  end

  assign status_o.cut_pass   = cut_pass;
  assign status_o.no_leptons = (lep_count_q == '0);
  assign status_o.last_issue = (CW'(rd_idx_q) == (lep_count_q - CW'(1)));
  assign status_o.pipe_busy  = v1_q || v2_q || v3_q;
  assign status_o.hit        = hit_q;

  assign result_valid_o = result_valid_q;
  assign jet_index_o    = jet_index_q;

  a_hit_from_compare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(hit_q) |-> $past(v3_q))
    else $error("overlap flag set without a distance compare");

  a_result_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_q |-> !$past(v1_q || v2_q || v3_q))
    else $error("result given with compares still in flight");

  a_full_store_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.store_lepton && lep_full) |=> $stable(lep_count_q))
    else $error("lepton count moved past capacity");

endmodule

/* src/jet_lepton_overlap_cleaner_unit.sv */
// A jet that passes the kinematic cut and overlaps no stored lepton gives its result strobe
// after the lepton scan (skipped with an empty list) and the pipeline drain; busy is high
// until then. Start, lepton and cut jets leave the block idle; a passing jet holds it busy
// through its scan, set by the single shared distance unit, one lepton per cycle.
// Reset (rst_ni low, asynchronous) empties the lepton list, zeroes the jet counter and
// loads the default limits; the receiver cannot stall, so results never back up.
module jet_lepton_overlap_cleaner_unit #(
  parameter int unsigned MAX_LEPTONS = 16,
  parameter int unsigned MAX_JETS    = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Item channel: a transfer happens when start is high and busy is low.
  input  logic                                 start,
  output logic                                 busy,
  input  logic [jloc_pkg::CMD_W-1:0]           cmd_i,
  input  logic signed [jloc_pkg::ETA_W-1:0]    eta_i,
  input  logic signed [jloc_pkg::PHI_W-1:0]    phi_i,
  input  logic [jloc_pkg::PT_W-1:0]            pt_i,
  // Configuration write channel.
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [jloc_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [jloc_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // Result strobe: valid for exactly one cycle per surviving jet.
  output logic                                 result_valid_o,
  output logic [jloc_pkg::JET_INDEX_W-1:0]     jet_index_o
);
  import jloc_pkg::*;

  // The controller decides what each transfer does and sequences the lepton scan;
  // the datapath holds the lepton store, the counters, the limits and a three-stage
  // distance pipeline (read, magnitudes, squares) whose compare sets an overlap flag.
  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  // The limit registers may be written in any cycle; the user is to write them only while
  // the block is idle, which the block itself does not enforce, so a write is never held off.
  assign cfg_ready_o = 1'b1;

  jloc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .cmd_i    (cmd_i),
    .status_i (dp_status),
    .cmd_o    (ctrl_cmd),
    .busy     (busy)
  );

  jloc_datapath #(
    .MAX_LEPTONS (MAX_LEPTONS),
    .MAX_JETS    (MAX_JETS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .eta_i          (eta_i),
    .phi_i          (phi_i),
    .pt_i           (pt_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (ctrl_cmd),
    .status_o       (dp_status),
    .result_valid_o (result_valid_o),
    .jet_index_o    (jet_index_o)
  );

endmodule

/* sim/tb_jet_lepton_overlap_cleaner_unit.sv */
module tb_jet_lepton_overlap_cleaner_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import jloc_pkg::*;

  // Sizes of the instance under test. The lepton list and the jet index
  // range follow from these.
  localparam int unsigned LEPTON_SLOTS = 16;
  localparam int unsigned JET_SLOTS    = 64;

  // The package names the three live commands; the fourth code is spare
  // and the block must swallow it without a result.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int CLK_HALF = 5;
  // A jet that is rejected by a stored lepton gives no strobe, yet keeps the
  // distance unit busy while it scans every stored lepton and the pipeline drains.
  // Before any register write we let that much time go by.
  localparam int DRAIN_CYCLES = LEPTON_SLOTS + 8;
  // Bound on waiting for outstanding results before a register write or at
  // the end of the run.
  localparam int SETTLE_LIMIT = 500;
  // Cycles without any transfer after which the run is declared hung.
  localparam int QUIET_LIMIT = 2000;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    start       = 1'b0;
  logic                    busy;
  logic [CMD_W-1:0]        cmd_i       = CMD_START;
  logic signed [ETA_W-1:0] eta_i       = '0;
  logic signed [PHI_W-1:0] phi_i       = '0;
  logic [PT_W-1:0]         pt_i        = '0;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_INDEX_W-1:0]  cfg_index_i = CFG_DR_LIMIT;
  logic [CFG_DATA_W-1:0]   cfg_data_i  = '0;
  logic                    result_valid_o;
  logic [JET_INDEX_W-1:0]  jet_index_o;

  // Our own picture of the cleaner: limits, lepton list and jet counter.
  logic [DR_W-1:0]         dr_limit_reg;
  logic [PT_W-1:0]         pt_min_reg;
  logic [ETA_MAX_W-1:0]    eta_max_reg;
  logic signed [ETA_W-1:0] lep_eta [LEPTON_SLOTS];
  logic signed [PHI_W-1:0] lep_phi [LEPTON_SLOTS];
  int unsigned             lepton_total;
  int unsigned             jet_count;

  // Indices of jets that are due to survive, oldest first.
  logic [JET_INDEX_W-1:0]  survivor_q [$];

  bit sender_idles = 1'b1;
  int error_count  = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int cfg_writes   = 0;
  int settings_run = 0;
  int quiet_cycles = 0;

  jet_lepton_overlap_cleaner_unit #(
    .MAX_LEPTONS(LEPTON_SLOTS),
    .MAX_JETS   (JET_SLOTS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .eta_i         (eta_i),
    .phi_i         (phi_i),
    .pt_i          (pt_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .result_valid_o(result_valid_o),
    .jet_index_o   (jet_index_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Works out what one accepted item does to the cleaner. A start clears the
  // event, a lepton is stored while there is room, and a jet takes the next
  // index (which sticks at the top of the range) and survives only if it
  // passes the pt and |eta| cuts and no stored lepton sits strictly inside
  // the deltaR squared limit. The phi difference wraps round the circle,
  // which is exactly a 12-bit two's complement subtraction.
  function automatic void evaluate_item(input logic [CMD_W-1:0] cmd,
                                        input logic signed [ETA_W-1:0] eta,
                                        input logic signed [PHI_W-1:0] phi,
                                        input logic [PT_W-1:0] pt);
    int unsigned             idx;
    int                      eta_mag;
    int                      deta;
    int                      dphi_mag;
    int unsigned             dist_sq;
    logic signed [PHI_W-1:0] dphi;
    bit                      close_lepton;
    idx          = jet_count;
    close_lepton = 1'b0;
    case (cmd)
      CMD_START: begin
        lepton_total = 0;
        jet_count    = 0;
      end
      CMD_LEPTON: begin
        if (lepton_total < LEPTON_SLOTS) begin
          lep_eta[lepton_total] = eta;
          lep_phi[lepton_total] = phi;
          lepton_total++;
        end
      end
      CMD_JET: begin
        if (jet_count < JET_SLOTS - 1) jet_count++;
        eta_mag = (eta < 0) ? -int'(eta) : int'(eta);
        if (pt >= pt_min_reg && eta_mag <= int'(eta_max_reg)) begin
          for (int i = 0; i < lepton_total; i++) begin
            deta     = int'(eta) - int'(lep_eta[i]);
            dphi     = phi - lep_phi[i];
            dphi_mag = (dphi < 0) ? -int'(dphi) : int'(dphi);
            dist_sq  = deta * deta + dphi_mag * dphi_mag;
            if (dist_sq < dr_limit_reg) close_lepton = 1'b1;
          end
          if (!close_lepton) survivor_q.insert(survivor_q.size(), idx[JET_INDEX_W-1:0]);
        end
      end
      default: ;
    endcase
  endfunction

  // Result checker and activity monitor. Everything is sampled at the
  // rising edge; the driver only moves at the falling edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || (cfg_valid_i && cfg_ready_o) || result_valid_o) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
      if (result_valid_o) begin
        results_seen = results_seen + 1;
        if (survivor_q.size() == 0) begin
          $error("jet_index: expected no result, got %0d", jet_index_o);
          error_count = error_count + 1;
        end else begin
          if (jet_index_o !== survivor_q[0]) begin
            $error("jet_index: expected %0d, got %0d", survivor_q[0], jet_index_o);
            error_count = error_count + 1;
          end
          void'(survivor_q.pop_front());
        end
      end
    end
  end

  // The run is considered hung once nothing has moved for a long time.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("Timed out after %0d cycles without a transfer.", QUIET_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // Offers one item and returns once its transfer has happened. Start is
  // left high so that back-to-back items keep it high; a gap lowers it at
  // a falling edge of its own before the next item raises it again.
  task automatic send_item(input logic [CMD_W-1:0] cmd,
                           input logic signed [ETA_W-1:0] eta,
                           input logic signed [PHI_W-1:0] phi,
                           input logic [PT_W-1:0] pt);
    int gap;
    if (sender_idles && $urandom_range(99) < 19) begin
      gap = ($urandom_range(3) == 0) ? $urandom_range(4, 25) : $urandom_range(1, 3);
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start <= 1'b1;
    cmd_i <= cmd;
    eta_i <= eta;
    phi_i <= phi;
    pt_i  <= pt;
    do @(posedge clk_i); while (busy);
    evaluate_item(cmd, eta, phi, pt);
    items_sent++;
  endtask

  // Stops offering items and waits until every expected result has turned
  // up, then for the time a rejected jet may still occupy the block.
  task automatic settle();
    int waited;
    waited = 0;
    @(negedge clk_i);
    start <= 1'b0;
    while (survivor_q.size() != 0 && waited < SETTLE_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (index)
      CFG_DR_LIMIT: dr_limit_reg = value[DR_W-1:0];
      CFG_PT_MIN:   pt_min_reg   = value[PT_W-1:0];
      CFG_ETA_MAX:  eta_max_reg  = value[ETA_MAX_W-1:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Registers are only touched while the block is quiet.
  task automatic apply_settings(input logic [DR_W-1:0] dr_limit,
                                input logic [PT_W-1:0] pt_min,
                                input logic [ETA_MAX_W-1:0] eta_max);
    settle();
    write_register(CFG_DR_LIMIT, CFG_DATA_W'(dr_limit));
    write_register(CFG_PT_MIN, CFG_DATA_W'(pt_min));
    write_register(CFG_ETA_MAX, CFG_DATA_W'(eta_max));
    settings_run++;
  endtask

  // Jet pt: anywhere, right at the cut, or comfortably above it.
  function automatic logic [PT_W-1:0] pick_pt();
    case ($urandom_range(3))
      0:       return PT_W'($urandom_range(16'hFFFF));
      1:       return PT_W'(pt_min_reg + $urandom_range(4) - 2);
      default: return PT_W'(pt_min_reg + $urandom_range(16'hFFFF - pt_min_reg));
    endcase
  endfunction

  // One event with random content. Leptons fall either anywhere or inside
  // the jet acceptance; jets are often placed around a stored lepton at a
  // random distance scale so that both sides of the deltaR limit are hit,
  // including exact overlap. Some spare commands and late leptons are mixed
  // in as noise, and the start transfer can be left out so that the event
  // carries on from whatever the block already holds.
  task automatic run_event(input int lepton_items, input int jet_items,
                           input bit open_event);
    logic signed [ETA_W-1:0] spot_eta [$];
    logic signed [PHI_W-1:0] spot_phi [$];
    logic signed [ETA_W-1:0] eta;
    logic signed [PHI_W-1:0] phi;
    int                      k;
    int                      span;
    if (open_event) begin
      send_item(CMD_START, ETA_W'($urandom), PHI_W'($urandom), PT_W'($urandom));
    end
    for (int n = 0; n < lepton_items + jet_items; n++) begin
      if (n < lepton_items || $urandom_range(14) == 0) begin
        if ($urandom_range(1)) begin
          eta = ETA_W'($urandom);
        end else begin
          eta = ETA_W'($urandom_range(2 * eta_max_reg) - eta_max_reg);
        end
        phi = PHI_W'($urandom);
        spot_eta.insert(spot_eta.size(), eta);
        spot_phi.insert(spot_phi.size(), phi);
        send_item(CMD_LEPTON, eta, phi, PT_W'($urandom));
      end
      if (n >= lepton_items) begin
        if (spot_eta.size() != 0 && $urandom_range(1)) begin
          k    = $urandom_range(spot_eta.size() - 1);
          span = 32 << $urandom_range(6);
          eta  = spot_eta[k];
          phi  = spot_phi[k];
          if ($urandom_range(3) != 0) begin
            eta = ETA_W'(spot_eta[k] + ($urandom_range(2 * span) - span));
            phi = PHI_W'(spot_phi[k] + ($urandom_range(2 * span) - span));
          end
        end else if ($urandom_range(1)) begin
          // Straddles the |eta| cut by one unit on either side.
          eta = ETA_W'($urandom_range(2 * eta_max_reg + 2) - eta_max_reg - 1);
          phi = PHI_W'($urandom);
        end else begin
          eta = ETA_W'($urandom);
          phi = PHI_W'($urandom);
        end
        send_item(CMD_JET, eta, phi, pick_pt());
      end
      if ($urandom_range(19) == 0) begin
        send_item(CMD_UNUSED, ETA_W'($urandom), PHI_W'($urandom), PT_W'($urandom));
      end
    end
  endtask

  // Default limits: pt cut at 100, |eta| cut at 1565, deltaR squared limit
  // of 261 squared. The very first jet comes before any start, with an empty
  // list, and the spare command is offered once. Two leptons then probe the
  // phi wrap, the exact deltaR boundary, both kinematic cuts on each side,
  // and the field extremes; a second start shows the index restarting.
  task automatic test_directed_cuts();
    send_item(CMD_JET, 0, 0, 16'd200);
    send_item(CMD_UNUSED, -1, -1, 16'hFFFF);
    send_item(CMD_START, 0, 0, 16'd0);
    send_item(CMD_LEPTON, 0, 2047, 16'd0);
    send_item(CMD_LEPTON, 1000, 0, 16'd0);
    send_item(CMD_JET, 0, -2048, 16'd500);
    send_item(CMD_JET, 1261, 0, 16'd100);
    send_item(CMD_JET, 1260, 0, 16'd100);
    send_item(CMD_JET, 1565, -1000, 16'd100);
    send_item(CMD_JET, -1565, 1000, 16'hFFFF);
    send_item(CMD_JET, 1566, 0, 16'd1000);
    send_item(CMD_JET, -4096, 0, 16'hFFFF);
    send_item(CMD_JET, 4095, 0, 16'hFFFF);
    send_item(CMD_JET, 0, -1000, 16'd99);
    send_item(CMD_JET, 0, -1000, 16'd0);
    send_item(CMD_JET, 0, -1000, 16'd100);
    send_item(CMD_START, -4096, -2048, 16'hFFFF);
    send_item(CMD_JET, 0, 2047, 16'd100);
  endtask

  // Sixteen far-away leptons fill the list; two more sit right on top of the
  // jet but must be dropped, so the jet still survives.
  task automatic test_lepton_overflow();
    send_item(CMD_START, 0, 0, 16'd0);
    for (int n = 0; n < LEPTON_SLOTS; n++) begin
      send_item(CMD_LEPTON, 4095, PHI_W'(n * 256), 16'd0);
    end
    send_item(CMD_LEPTON, 0, 0, 16'd0);
    send_item(CMD_LEPTON, 1, 1, 16'd0);
    send_item(CMD_JET, 0, 0, 16'd100);
  endtask

  // More jets than the index range holds: the later ones share the top
  // index. Jets are kept inside the acceptance so most of them report.
  task automatic test_index_saturation();
    send_item(CMD_START, ETA_W'($urandom), PHI_W'($urandom), PT_W'($urandom));
    for (int n = 0; n < JET_SLOTS + 6; n++) begin
      send_item(CMD_JET, ETA_W'($urandom_range(2 * eta_max_reg) - eta_max_reg),
                PHI_W'($urandom), pick_pt());
    end
  endtask

  // Every register at both ends of its range, then one mixed setting, then back to the defaults.
  task automatic test_register_extremes();
    for (int s = 0; s < 4; s++) begin
      case (s)
        0:       apply_settings('0, '0, '1);
        1:       apply_settings('1, '1, '0);
        2:       apply_settings(DR_W'(1), PT_W'(16'h8000), ETA_MAX_W'(12'h800));
        default: apply_settings(DR_LIMIT_RESET, PT_MIN_RESET, ETA_MAX_RESET);
      endcase
      run_event(3, 4, 1'b1);
      run_event(0, 2, 1'b1);
      send_item(CMD_JET, 0, 0, 16'hFFFF);
    end
  endtask

  // Random settings per phase, mostly well-formed events. One phase runs
  // with the sender never idling, and now and then the sender holds off
  // until every outstanding result has come back.
  task automatic test_random_events();
    int               phase_end;
    logic [DR_W-1:0]  dr_limit;
    for (int phase = 0; phase < 6; phase++) begin
      case ($urandom_range(2))
        0:       dr_limit = DR_W'($urandom_range(27'h7FFFFFF));
        1:       dr_limit = DR_W'($urandom_range(300000));
        default: dr_limit = DR_LIMIT_RESET;
      endcase
      apply_settings(dr_limit,
                     PT_W'(($urandom_range(3) == 0) ? $urandom_range(16'hFFFF)
                                                    : $urandom_range(400)),
                     ETA_MAX_W'($urandom_range(12'hFFF)));
      sender_idles = (phase != 2);
      phase_end    = items_sent + 45;
      while (items_sent < phase_end) begin
        run_event(($urandom_range(4) == 0) ? $urandom_range(12, 18) : $urandom_range(5),
                  $urandom_range(1, 8), $urandom_range(9) != 0);
        if ($urandom_range(3) == 0) settle();
      end
    end
    sender_idles = 1'b1;
  endtask

  initial begin
    dr_limit_reg = DR_LIMIT_RESET;
    pt_min_reg   = PT_MIN_RESET;
    eta_max_reg  = ETA_MAX_RESET;
    lepton_total = 0;
    jet_count    = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cuts();
    test_lepton_overflow();
    test_index_saturation();
    test_register_extremes();
    test_random_events();
    settle();

    if (survivor_q.size() != 0) begin
      $error("jet_index: expected %0d, got none (%0d results missing)",
             survivor_q[0], survivor_q.size());
      error_count++;
    end
    $display("Sent %0d items under %0d register settings (%0d register writes).",
             items_sent, settings_run, cfg_writes);
    $display("Checked %0d surviving-jet results; %0d mismatches.", results_seen, error_count);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
src/jloc_pkg.sv
src/jloc_ctrl.sv
src/jloc_datapath.sv
src/jet_lepton_overlap_cleaner_unit.sv
sim/tb_jet_lepton_overlap_cleaner_unit.sv
